[hdl/trailing_moving_average_assert.svh]
// assertion macros shared by the moving average modules
`ifndef TRAILING_MOVING_AVERAGE_ASSERT_SVH
`define TRAILING_MOVING_AVERAGE_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define TMA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tma assertion failed");

// next-cycle implication, disabled while reset is asserted
`define TMA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tma assertion failed");

`endif

[hdl/tma_pkg.sv]
// shared constants, types and helpers of the trailing moving average
`timescale 1ns / 1ps
`default_nettype none

package tma_pkg;

    localparam int MAX_WINDOW = 64;
    localparam int DATA_W     = 32;
    localparam int CFG_W      = 7;
    localparam int SLOT_W     = $clog2(MAX_WINDOW);
    localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W      = DATA_W + SLOT_W;
    localparam int ITER_W     = $clog2(SUM_W);
    localparam logic [CFG_W-1:0] WINDOW_RESET = CFG_W'(4);

    typedef struct packed {
        logic cfg_write;
        logic accept;
        logic read_old;
        logic update;
        logic div_load;
        logic div_step;
        logic out_load;
    } t_ctrl_cmd;

    typedef struct packed {
        logic div_last;
    } t_dp_status;

    function automatic logic [CNT_W-1:0] eff_window(input logic [CFG_W-1:0] v);
        logic [CNT_W-1:0] w;
        if (v == '0) begin
            w = CNT_W'(1);
        end else if (int'(v) > MAX_WINDOW) begin
            w = CNT_W'(MAX_WINDOW);
        end else begin
            w = CNT_W'(v);
        end
        return w;
    endfunction

endpackage

`default_nettype wire

[hdl/tma_datapath.sv]
// sample ring, running sum, fill count, serial divider and output register
`timescale 1ns / 1ps
`default_nettype none

`include "trailing_moving_average_assert.svh"

module tma_datapath (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire tma_pkg::t_ctrl_cmd                i_cmd,
    output tma_pkg::t_dp_status                    o_status,
    input  wire logic [tma_pkg::CFG_W-1:0]         i_cfg_data,
    input  wire logic signed [tma_pkg::DATA_W-1:0] i_sample,
    input  wire logic                              i_first_of_set,
    output logic signed [tma_pkg::DATA_W-1:0]      o_average
);

    localparam int DW = tma_pkg::DATA_W;
    localparam int SW = tma_pkg::SUM_W;
    localparam int CW = tma_pkg::CNT_W;
    localparam int LW = tma_pkg::SLOT_W;
    localparam int IW = tma_pkg::ITER_W;

    logic [DW-1:0] r_ring [tma_pkg::MAX_WINDOW];
    logic [DW-1:0] r_ring_q;

    logic [tma_pkg::CFG_W-1:0] r_window;
    logic signed [SW-1:0]      r_sum,  n_sum;
    logic [CW-1:0]             r_fill, n_fill;
    logic [LW-1:0]             r_slot, n_slot;
    logic [DW-1:0]             r_sample;

    logic [SW-1:0]   r_quo;
    logic [CW:0]     r_rem;
    logic [CW-1:0]   r_div;
    logic            r_neg;
    logic [IW-1:0]   r_iter;
    logic [DW-1:0]   r_average;

    logic [CW-1:0]        w_eff;
    logic [CW-1:0]        slot_x;
    logic [LW-1:0]        old_addr;
    logic                 full;
    logic signed [SW-1:0] sample_ext;
    logic signed [SW-1:0] old_ext;
    logic [SW-1:0]        mag;
    logic [CW:0]          trial;
    logic                 ge;
    logic [SW-1:0]        quo_signed;

    assign w_eff  = tma_pkg::eff_window(r_window);
    assign slot_x = CW'(r_slot);
    assign full   = (r_fill >= w_eff);

    // oldest slot of the window, wrapping around the ring
    always_comb begin
        if (slot_x >= w_eff) begin
            old_addr = LW'(slot_x - w_eff);
        end else begin
            old_addr = LW'(slot_x + CW'(tma_pkg::MAX_WINDOW) - w_eff);
        end
    end

    assign sample_ext = {{(SW-DW){r_sample[DW-1]}}, r_sample};
    assign old_ext    = {{(SW-DW){r_ring_q[DW-1]}}, r_ring_q};

    always_comb begin
        n_sum  = r_sum;
        n_fill = r_fill;
        n_slot = r_slot;
        if (i_cmd.update) begin
            if (full) begin
                n_sum  = r_sum - old_ext + sample_ext;
                n_fill = w_eff;
            end else begin
                n_sum  = r_sum + sample_ext;
                n_fill = r_fill + CW'(1);
            end
            if (r_slot == LW'(tma_pkg::MAX_WINDOW - 1)) begin
                n_slot = '0;
            end else begin
                n_slot = r_slot + LW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= tma_pkg::WINDOW_RESET;
            r_sum    <= '0;
            r_fill   <= '0;
            r_slot   <= '0;
        end else if (i_cmd.cfg_write) begin
            r_window <= i_cfg_data;
            r_sum    <= '0;
            r_fill   <= '0;
            r_slot   <= '0;
        end else if (i_cmd.accept && i_first_of_set) begin
            r_sum    <= '0;
            r_fill   <= '0;
            r_slot   <= '0;
        end else begin
            r_sum    <= n_sum;
            r_fill   <= n_fill;
            r_slot   <= n_slot;
        end
    end

    // ring memory: one write and one registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_ring[r_slot] <= r_sample;
        end
        if (i_cmd.read_old) begin
            r_ring_q <= r_ring[old_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_sample <= i_sample;
        end
    end

    // restoring divide of the sum magnitude, one quotient bit per cycle
    assign mag   = r_sum[SW-1] ? SW'(-r_sum) : SW'(r_sum);
    assign trial = {r_rem[CW-1:0], r_quo[SW-1]};
    assign ge    = (trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iter <= '0;
        end else if (i_cmd.div_load) begin
            r_iter <= IW'(SW - 1);
        end else if (i_cmd.div_step) begin
            r_iter <= r_iter - IW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_load) begin
            r_quo <= mag;
            r_rem <= '0;
            r_div <= r_fill;
            r_neg <= r_sum[SW-1];
        end else if (i_cmd.div_step) begin
            r_quo <= {r_quo[SW-2:0], ge};
            r_rem <= ge ? (trial - {1'b0, r_div}) : trial;
        end
    end

    assign quo_signed = r_neg ? (~r_quo + SW'(1)) : r_quo;

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_average <= quo_signed[DW-1:0];
        end
    end

    assign o_average         = r_average;
    assign o_status.div_last = (r_iter == '0);

    `TMA_ASSERT_NOW(a_fill_within_window, i_clk, i_rst_n, 1'b1, r_fill <= w_eff)
    `TMA_ASSERT_NEXT(a_fill_nonzero_after_update, i_clk, i_rst_n, i_cmd.update, r_fill != '0)
    `TMA_ASSERT_NEXT(a_divisor_nonzero, i_clk, i_rst_n, i_cmd.div_load, r_div != '0)

endmodule

`default_nettype wire

[hdl/tma_ctrl.sv]
// controller state machine and output valid of the moving average
`timescale 1ns / 1ps
`default_nettype none

`include "trailing_moving_average_assert.svh"

module tma_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_stall,
    output logic                     o_valid,
    input  wire logic                i_stall,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    output tma_pkg::t_ctrl_cmd       o_cmd,
    input  wire tma_pkg::t_dp_status i_status
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_READ   = 6'b000010,
        S_UPDATE = 6'b000100,
        S_LOAD   = 6'b001000,
        S_DIV    = 6'b010000,
        S_DONE   = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid;
    logic   item_acc;
    logic   cfg_acc;
    logic   out_free;

    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_stall     = (r_state != S_IDLE) || i_cfg_valid;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;
    assign item_acc    = i_valid && !o_stall;
    assign out_free    = !r_out_valid || !i_stall;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (item_acc) begin
                    n_state = S_READ;
                end
            end
            S_READ:   n_state = S_UPDATE;
            S_UPDATE: n_state = S_LOAD;
            S_LOAD:   n_state = S_DIV;
            S_DIV: begin
                if (i_status.div_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd           = '0;
        o_cmd.cfg_write = cfg_acc;
        o_cmd.accept    = item_acc;
        o_cmd.read_old  = (r_state == S_READ);
        o_cmd.update    = (r_state == S_UPDATE);
        o_cmd.div_load  = (r_state == S_LOAD);
        o_cmd.div_step  = (r_state == S_DIV);
        o_cmd.out_load  = (r_state == S_DONE) && out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid = r_out_valid;

    `TMA_ASSERT_NOW(a_no_result_overwrite, i_clk, i_rst_n, o_cmd.out_load, out_free)
    `TMA_ASSERT_NEXT(a_accept_starts_read, i_clk, i_rst_n, item_acc, r_state == S_READ)
    `TMA_ASSERT_NEXT(a_div_exit, i_clk, i_rst_n, (r_state == S_DIV) && i_status.div_last, r_state == S_DONE)

endmodule

`default_nettype wire

[hdl/trailing_moving_average.sv]
// top level of the trailing simple moving average over Q16.16 samples
//
//  channel   direction  handshake                 payload
//  input     in         i_valid / o_stall         i_sample, i_first_of_set
//  output    out        o_valid / i_stall         o_average
//  config    in         i_cfg_valid / o_cfg_ready i_cfg_data (window length)
//
// a new item is accepted only once the previous item has been written to the output register
// each item includes the bit-serial divide of the running sum by the fill count
// the result sits in an output register, so a stalled output only holds the last step
// synchronous active-low reset sets window length 4 and an empty window
// a config write or an item with first_of_set clears the window
`timescale 1ns / 1ps
`default_nettype none

module trailing_moving_average (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_stall,
    input  wire logic signed [tma_pkg::DATA_W-1:0] i_sample,
    input  wire logic                              i_first_of_set,
    output logic                                   o_valid,
    input  wire logic                              i_stall,
    output logic signed [tma_pkg::DATA_W-1:0]      o_average,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [tma_pkg::CFG_W-1:0]         i_cfg_data
);

    tma_pkg::t_ctrl_cmd  cmd;
    tma_pkg::t_dp_status status;

    tma_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    tma_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_cfg_data     (i_cfg_data),
        .i_sample       (i_sample),
        .i_first_of_set (i_first_of_set),
        .o_average      (o_average)
    );

endmodule

`default_nettype wire

[tb/trailing_moving_average_tb.sv]
// self-checking testbench for the trailing moving average with a scoreboard class
`timescale 1ns / 1ps

class moving_mean_model;

    logic signed [tma_pkg::DATA_W-1:0] ring [tma_pkg::MAX_WINDOW];
    logic signed [tma_pkg::DATA_W-1:0] pending_means [$];
    longint                            acc_sum;
    int unsigned                       fill;
    int unsigned                       slot;
    int unsigned                       window_cfg;
    int                                mismatches;

    function new();
        window_cfg = 4;
        mismatches = 0;
        clear_window();
    endfunction

    function void clear_window();
        acc_sum = 0;
        fill    = 0;
        slot    = 0;
    endfunction

    function void set_window(logic [tma_pkg::CFG_W-1:0] value);
        window_cfg = 32'(value);
        clear_window();
    endfunction

    function int pending();
        return pending_means.size();
    endfunction

    function void take_sample(logic signed [tma_pkg::DATA_W-1:0] s, logic first);
        int unsigned w;
        int unsigned old;
        longint      mean;
        w = window_cfg;
        if (w == 0) begin
            w = 1;
        end
        if (w > tma_pkg::MAX_WINDOW) begin
            w = tma_pkg::MAX_WINDOW;
        end
        if (first) begin
            clear_window();
        end
        if (fill >= w) begin
            // retire the oldest sample of the full window
            old = (slot + tma_pkg::MAX_WINDOW - w) % tma_pkg::MAX_WINDOW;
            acc_sum -= longint'(ring[old]);
            fill = w;
        end else begin
            fill++;
        end
        ring[slot] = s;
        acc_sum += longint'(s);
        slot = (slot + 1) % tma_pkg::MAX_WINDOW;
        mean = acc_sum / longint'(fill);
        pending_means = {pending_means, mean[tma_pkg::DATA_W-1:0]};
    endfunction

    function void check_average(logic signed [tma_pkg::DATA_W-1:0] got);
        logic signed [tma_pkg::DATA_W-1:0] want;
        if (pending_means.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("unexpected average %0d with nothing pending", got);
            end
            return;
        end
        want = pending_means.pop_front();
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("average mismatch: expected %0d (%h), got %0d (%h)",
                         want, want, got, got);
            end
        end
    endfunction

endclass

module trailing_moving_average_tb;

    typedef enum int {STALL_NONE, STALL_RANDOM, STALL_HEAVY} t_stall_mode;
    typedef enum int {SET_MIXED, SET_HIGH, SET_LOW, SET_TINY} t_set_style;

    localparam int IDLE_LIMIT = 5000;
    localparam int NUM_PHASES = 8;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              i_valid = 1'b0;
    logic                              o_stall;
    logic signed [tma_pkg::DATA_W-1:0] i_sample = '0;
    logic                              i_first_of_set = 1'b0;
    logic                              o_valid;
    logic                              i_stall = 1'b0;
    logic signed [tma_pkg::DATA_W-1:0] o_average;
    logic                              i_cfg_valid = 1'b0;
    logic                              o_cfg_ready;
    logic [tma_pkg::CFG_W-1:0]         i_cfg_data = '0;

    moving_mean_model model = new();

    int          burst_left = 0;
    int          stall_span = 0;
    t_stall_mode stall_mode = STALL_NONE;
    int          idle_cycles = 0;

    trailing_moving_average dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_sample       (i_sample),
        .i_first_of_set (i_first_of_set),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_average      (o_average),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // receiver stall pattern, switching between modes
    always @(posedge i_clk) begin
        if (stall_span == 0) begin
            stall_span <= $urandom_range(30, 400);
            stall_mode <= t_stall_mode'($urandom_range(0, 2));
        end else begin
            stall_span <= stall_span - 1;
        end
        case (stall_mode)
            STALL_NONE: begin
                i_stall <= 1'b0;
            end
            STALL_RANDOM: begin
                i_stall <= 1'($urandom_range(0, 1));
            end
            default: begin
                i_stall <= ($urandom_range(0, 7) != 0);
            end
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            model.check_average(o_average);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("trailing_moving_average verification failed");
            $finish;
        end
    end

    task automatic send_sample(input logic signed [tma_pkg::DATA_W-1:0] s,
                               input logic first);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 80);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 8);
        end
        i_valid        <= 1'b1;
        i_sample       <= s;
        i_first_of_set <= first;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        model.take_sample(s, first);
        burst_left--;
    endtask

    task automatic write_window(input logic [tma_pkg::CFG_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        model.set_window(value);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (model.pending() != 0) @(posedge i_clk);
    endtask

    function automatic logic signed [tma_pkg::DATA_W-1:0] pick_sample(t_set_style style);
        int r;
        int tiny;
        logic signed [tma_pkg::DATA_W-1:0] s;
        tiny = $urandom_range(0, 2000);
        tiny = tiny - 1000;
        case (style)
            SET_HIGH: begin
                s = 32'h7FFF_FFFF - $urandom_range(0, 255);
            end
            SET_LOW: begin
                s = 32'h8000_0000 + $urandom_range(0, 255);
            end
            SET_TINY: begin
                s = tiny;
            end
            default: begin
                r = $urandom_range(0, 9);
                case (r)
                    0: s = 32'h7FFF_FFFF;
                    1: s = 32'h8000_0000;
                    2: s = tiny;
                    default: s = $urandom;
                endcase
            end
        endcase
        return s;
    endfunction

    task automatic run_directed();
        logic signed [tma_pkg::DATA_W-1:0] samples [22] = '{
            32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
            32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
            32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF,
            32'h0000_0000, 32'hFFFF_FFFE, 32'h0001_0000, 32'hFFFF_0000,
            32'h0001_8000, 32'h0000_0001, 32'h0000_0005, 32'h0000_0002,
            32'h7FFF_FFFF, 32'h8000_0000
        };
        logic firsts [22] = '{
            1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0,
            1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0
        };
        for (int k = 0; k < 22; k++) begin
            send_sample(samples[k], firsts[k]);
        end
    endtask

    task automatic run_phase(input int count, input int span);
        int         set_left;
        int         r;
        t_set_style style;
        logic       first;
        set_left = 0;
        style    = SET_MIXED;
        for (int k = 0; k < count; k++) begin
            first = 1'b0;
            if (set_left == 0) begin
                // new dataset, usually long enough to fill the window
                first    = ($urandom_range(0, 7) != 0);
                set_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4)
                                                       : $urandom_range(span, 2 * span + 8);
                r        = $urandom_range(0, 5);
                style    = (r < 3) ? SET_MIXED : t_set_style'(r - 2);
            end else if ($urandom_range(0, 39) == 0) begin
                first = 1'b1;
            end
            set_left--;
            send_sample(pick_sample(style), first);
        end
        i_valid <= 1'b0;
    endtask

    initial begin
        logic [tma_pkg::CFG_W-1:0] phase_window [NUM_PHASES];
        int                        phase_items [NUM_PHASES];
        int                        span;
        phase_window = '{7'd1, 7'd0, 7'd64, 7'd127, 7'd2, 7'd65, 7'd0, 7'd0};
        phase_items  = '{80, 60, 150, 130, 80, 70, 100, 110};
        phase_window[6] = 7'($urandom_range(3, 63));
        phase_window[7] = 7'($urandom_range(0, 127));
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset window length first
        run_directed();
        run_phase(70, 4);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            wait_drained();
            write_window(phase_window[ph]);
            span = (phase_window[ph] == 0) ? 1
                 : (phase_window[ph] > tma_pkg::MAX_WINDOW) ? tma_pkg::MAX_WINDOW
                 : int'(phase_window[ph]);
            run_phase(phase_items[ph], span);
        end

        wait_drained();
        repeat (60) @(posedge i_clk);
        if (model.mismatches == 0 && model.pending() == 0) begin
            $display("trailing_moving_average verification clean");
        end else begin
            $display("trailing_moving_average verification failed");
        end
        $finish;
    end

endmodule
